[rtl/pbrt_pkg.sv]
`timescale 1ns / 1ps

package pbrt_pkg;

   localparam int MAX_PIECES = 4096;
   localparam int WORD_BITS  = 64;
   localparam int WORDS      = MAX_PIECES / WORD_BITS;
   localparam int PIECE_W    = $clog2(MAX_PIECES);
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int ADDR_W     = $clog2(WORDS);
   localparam int TONES_W    = BIT_W + 1;
   localparam int CNT_W      = 13;
   localparam int LEN_W      = 25;
   localparam int OFS_W      = 24;
   localparam int BYTES_W    = 37;
   localparam int OP_W       = 2;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [OP_W-1:0] {
      OP_MARK  = 2'd0,
      OP_QUERY = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PIECE_COUNT = 2'd0,
      CSR_PIECE_LEN   = 2'd1,
      CSR_LAST_LEN    = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_QRY_RD,
      ST_QRY_SCAN,
      ST_QRY_MUL,
      ST_QRY_SUM,
      ST_QRY_SUB
   } state_type;

endpackage

[rtl/pbrt_ram.sv]
`timescale 1ns / 1ps

module pbrt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

[rtl/piece_bitmap_run_tracker_core.sv]
`timescale 1ns / 1ps

// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------
// request   req_operation/piece/span_last/offset    start & !busy
// response  rsp_piece_done ... rsp_done_total       rsp_valid, one-cycle strobe
// config    csr_index, csr_wdata                    csr_valid & csr_ready
//
// Mark: word read, read-modify-write, result; a piece out of range goes straight
// to the result. Clear and unused opcode go straight to the result; on a clear
// the row valid bits drop at once. Query: word read, a scan that the single read
// port of the 64 x 64-bit bitmap RAM feeds one word a cycle into the run counter,
// then multiply, sum, subtract and result; a start piece out of range skips the
// read and the scan. Reset is synchronous; all 64 row valid bits clear with it, so
// no sweep is needed. The result is a strobe and cannot be stalled; busy stays high
// until the result cycle is over.

module piece_bitmap_run_tracker_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [pbrt_pkg::OP_W-1:0]         req_operation,
   input  logic [pbrt_pkg::PIECE_W-1:0]      req_piece,
   input  logic [pbrt_pkg::PIECE_W-1:0]      req_span_last,
   input  logic [pbrt_pkg::OFS_W-1:0]        req_offset_in_piece,
   output logic                              rsp_valid,
   output logic                              rsp_piece_done,
   output logic                              rsp_span_done,
   output logic [pbrt_pkg::CNT_W-1:0]        rsp_run_pieces,
   output logic [pbrt_pkg::BYTES_W-1:0]      rsp_run_bytes,
   output logic [pbrt_pkg::CNT_W-1:0]        rsp_done_total,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pbrt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pbrt_pkg::LEN_W-1:0]        csr_wdata
);

   import pbrt_pkg::*;

   // control state
   state_type              state_ff, state_in;
   logic                   rsp_ff, rsp_in;
   logic [WORDS-1:0]       row_valid_ff, row_valid_in;
   logic                   rd_valid_ff;
   logic [CNT_W-1:0]       counter_ff, counter_in;

   // configuration
   logic [CNT_W-1:0]       pc_ff;
   logic [LEN_W-1:0]       plen_ff, lplen_ff;

   // item and datapath
   op_type                 op_ff, op_in;
   logic [PIECE_W-1:0]     piece_ff, piece_in;
   logic [PIECE_W-1:0]     last_ff, last_in;
   logic [OFS_W-1:0]       offset_ff, offset_in;
   logic [ADDR_W-1:0]      word_ff, word_in;
   logic                   first_ff, first_in;
   logic                   incl_last_ff, incl_last_in;
   logic [CNT_W-1:0]       run_ff, run_in;
   logic                   sdone_ff, sdone_in;
   logic [BYTES_W-1:0]     prod_ff, prod_in;
   logic [BYTES_W-1:0]     sum_ff, sum_in;
   logic [BYTES_W-1:0]     run_bytes;

   // RAM port signals
   logic                   wr_en;
   logic [ADDR_W-1:0]      rd_addr;
   logic [WORD_BITS-1:0]   rd_data, wr_data, word_data;

   // scan unit signals
   logic [CNT_W-1:0]       n_use;
   logic                   accept;
   logic                   start_in_range;
   logic [BIT_W-1:0]       bit_pos;
   logic [PIECE_W-1:0]     base;
   logic [CNT_W-1:0]       rem;
   logic [WORD_BITS-1:0]   range_mask, low_mask, scan_word;
   logic [TONES_W-1:0]     tones;
   logic                   scan_more;
   logic [PIECE_W-1:0]     span_diff;
   logic [CNT_W-1:0]       mult_run;
   logic [CNT_W+LEN_W-1:0] mult_full;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE) || rsp_ff;
   assign csr_ready = 1'b1;
   assign n_use     = (pc_ff > CNT_W'(MAX_PIECES)) ? CNT_W'(MAX_PIECES) : pc_ff;
   assign start_in_range = {1'b0, req_piece} < n_use;

   pbrt_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (WORDS)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (piece_ff[PIECE_W-1:BIT_W]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stream the next word while the current one is consumed
   assign rd_addr   = (state_ff == ST_QRY_SCAN) ? word_ff + ADDR_W'(1)
                                                : piece_ff[PIECE_W-1:BIT_W];
   // rows never written since the last clear read as empty
   assign word_data = rd_valid_ff ? rd_data : '0;

   // scan unit: count trailing complete pieces in the current word
   assign bit_pos  = first_ff ? piece_ff[BIT_W-1:0] : '0;
   assign base     = {word_ff, {BIT_W{1'b0}}};
   assign rem      = n_use - {1'b0, base};
   assign range_mask = (rem >= CNT_W'(WORD_BITS)) ? '1
                     : (WORD_BITS'(1) << rem[BIT_W-1:0]) - WORD_BITS'(1);
   assign low_mask  = (WORD_BITS'(1) << bit_pos) - WORD_BITS'(1);
   assign scan_word = (word_data & range_mask) | low_mask;

   always_comb begin
      tones = TONES_W'(WORD_BITS);
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (!scan_word[i]) begin
            tones = TONES_W'(i);
         end
      end
   end

   assign scan_more = (tones == TONES_W'(WORD_BITS))
                   && (({1'b0, base} + CNT_W'(WORD_BITS)) < n_use);

   assign span_diff = last_ff - piece_ff;
   assign mult_run  = incl_last_ff ? run_ff - CNT_W'(1) : run_ff;
   assign mult_full = mult_run * plen_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      rsp_in   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_MARK: begin
                     if (start_in_range) begin
                        state_in = ST_MARK_RD;
                     end else begin
                        rsp_in = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     state_in = start_in_range ? ST_QRY_RD : ST_QRY_MUL;
                  end
                  default: begin
                     rsp_in = 1'b1;
                  end
               endcase
            end
         end
         ST_MARK_RD: state_in = ST_MARK_WR;
         ST_MARK_WR: begin
            state_in = ST_IDLE;
            rsp_in   = 1'b1;
         end
         ST_QRY_RD: state_in = ST_QRY_SCAN;
         ST_QRY_SCAN: begin
            if (!scan_more) begin
               state_in = ST_QRY_MUL;
            end
         end
         ST_QRY_MUL: state_in = ST_QRY_SUM;
         ST_QRY_SUM: state_in = ST_QRY_SUB;
         ST_QRY_SUB: begin
            state_in = ST_IDLE;
            rsp_in   = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      op_in        = op_ff;
      piece_in     = piece_ff;
      last_in      = last_ff;
      offset_in    = offset_ff;
      word_in      = word_ff;
      first_in     = first_ff;
      incl_last_in = incl_last_ff;
      run_in       = run_ff;
      sdone_in     = sdone_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      counter_in   = counter_ff;
      row_valid_in = row_valid_ff;
      wr_en        = 1'b0;
      wr_data      = word_data | (WORD_BITS'(1) << piece_ff[BIT_W-1:0]);
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in     = op_type'(req_operation);
               piece_in  = req_piece;
               last_in   = req_span_last;
               offset_in = req_offset_in_piece;
               word_in   = req_piece[PIECE_W-1:BIT_W];
               first_in  = 1'b1;
               run_in    = '0;
               sdone_in  = 1'b0;
               if (op_type'(req_operation) == OP_CLEAR) begin
                  row_valid_in = '0;
                  counter_in   = '0;
               end
            end
         end
         ST_MARK_WR: begin
            // set the bit and count it only on a first mark
            if (!word_data[piece_ff[BIT_W-1:0]]) begin
               wr_en                                   = 1'b1;
               row_valid_in[piece_ff[PIECE_W-1:BIT_W]] = 1'b1;
               counter_in                              = counter_ff + CNT_W'(1);
            end
         end
         ST_QRY_SCAN: begin
            run_in   = run_ff + CNT_W'(tones) - CNT_W'(bit_pos);
            word_in  = word_ff + ADDR_W'(1);
            first_in = 1'b0;
         end
         ST_QRY_MUL: begin
            incl_last_in = ({1'b0, piece_ff} + run_ff) == n_use;
            sdone_in     = (last_ff < piece_ff) || (run_ff > CNT_W'(span_diff));
         end
         ST_QRY_SUM: begin
            prod_in = mult_full[BYTES_W-1:0];
         end
         ST_QRY_SUB: begin
            sum_in = prod_ff + (incl_last_ff ? BYTES_W'(lplen_ff) : '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_ff       <= 1'b0;
         row_valid_ff <= '0;
         counter_ff   <= '0;
         pc_ff        <= '0;
         plen_ff      <= LEN_W'(262144);
         lplen_ff     <= LEN_W'(262144);
      end else begin
         state_ff     <= state_in;
         rsp_ff       <= rsp_in;
         row_valid_ff <= row_valid_in;
         counter_ff   <= counter_in;
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_PIECE_COUNT: pc_ff    <= csr_wdata[CNT_W-1:0];
               CSR_PIECE_LEN:   plen_ff  <= csr_wdata;
               CSR_LAST_LEN:    lplen_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff  <= row_valid_ff[rd_addr];
      op_ff        <= op_in;
      piece_ff     <= piece_in;
      last_ff      <= last_in;
      offset_ff    <= offset_in;
      word_ff      <= word_in;
      first_ff     <= first_in;
      incl_last_ff <= incl_last_in;
      run_ff       <= run_in;
      sdone_ff     <= sdone_in;
      prod_ff      <= prod_in;
      sum_ff       <= sum_in;
   end

   // the result fields are formed in the strobe cycle from settled registers;
   // clamp the run total against the start offset, drop it for an empty run
   always_comb begin
      run_bytes = '0;
      if (op_ff == OP_QUERY && run_ff != '0 && sum_ff > BYTES_W'(offset_ff)) begin
         run_bytes = sum_ff - BYTES_W'(offset_ff);
      end
   end

   assign rsp_valid      = rsp_ff;
   assign rsp_piece_done = (op_ff == OP_QUERY) && (run_ff != '0);
   assign rsp_span_done  = (op_ff == OP_QUERY) && sdone_ff;
   assign rsp_run_pieces = (op_ff == OP_QUERY) ? run_ff : '0;
   assign rsp_run_bytes  = run_bytes;
   assign rsp_done_total = counter_ff;

endmodule
